FILE: rtl/core/ebc_pkg.sv
// shared types, coefficient table and microprogram for the eeg biquad cascade
package ebc_pkg;

  // fixed filter set and arithmetic constants
  localparam int COEF_SETS   = 4;
  localparam int COEF_TAPS   = 5;
  localparam int COEF_W      = 19;
  localparam int PROD_SHIFT  = 16;
  localparam int ROUND_HALF  = 32768;
  localparam int SAMPLE_W    = 12;
  localparam int X_FRAC      = 12;
  localparam int OUT_W       = 20;
  localparam int OUT_SHIFT   = 8;
  localparam int OUT_ROUND   = 128;
  localparam int SEC_W       = 2;
  localparam int PC_W        = 3;
  localparam int UPROG_LEN   = 8;
  localparam logic [SAMPLE_W-1:0] MIDPOINT_RESET = 12'h800;

  // coefficients in Q16: b0, b1, b2, a1, a2 for each section
  localparam logic signed [COEF_W-1:0] COEF_TAB [0:COEF_SETS-1][0:COEF_TAPS-1] = '{
    '{19'sd64644, -19'sd129288, 19'sd64644, -19'sd129288, 19'sd63765},
    '{19'sd65536,  19'sd131072, 19'sd65536,  -19'sd96698, 19'sd38464},
    '{19'sd65536, -19'sd131072, 19'sd65536, -19'sd111474, 19'sd51229},
    '{19'sd1826,     19'sd3652,  19'sd1826, -19'sd123494, 19'sd58495}
  };

  // microword field codes
  typedef enum logic [2:0] {CF_B0, CF_B1, CF_B2, CF_A1, CF_A2} coef_sel_t;
  typedef enum logic [1:0] {SRC_Z1, SRC_Z2, SRC_W} mul_src_t;
  typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD_X, ACC_SUB, ACC_ADD, ACC_LOAD_P} acc_op_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_END} jump_t;
  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  // one control word
  typedef struct packed {
    coef_sel_t coef;
    mul_src_t  src;
    logic      mul_en;
    acc_op_t   acc;
    logic      w_load;
    logic      sec_end;
    jump_t     jmp;
    logic      finish;
  } uword_t;

  // control bundle from sequencer to datapath
  typedef struct packed {
    uword_t             uw;
    logic               fire;
    logic               start;
    logic [SEC_W-1:0]   sec;
  } ebc_ctl_t;

  // per-section program: w = x - a1*z1 - a2*z2, y = b0*w + b1*z1 + b2*z2
  localparam uword_t UPROG [0:UPROG_LEN-1] = '{
    '{coef: CF_A1, src: SRC_Z1, mul_en: 1'b1, acc: ACC_LOAD_X, w_load: 1'b0,
      sec_end: 1'b0, jmp: JMP_NEXT, finish: 1'b0},
    '{coef: CF_A2, src: SRC_Z2, mul_en: 1'b1, acc: ACC_SUB, w_load: 1'b0,
      sec_end: 1'b0, jmp: JMP_NEXT, finish: 1'b0},
    '{coef: CF_B1, src: SRC_Z1, mul_en: 1'b1, acc: ACC_SUB, w_load: 1'b0,
      sec_end: 1'b0, jmp: JMP_NEXT, finish: 1'b0},
    '{coef: CF_B2, src: SRC_Z2, mul_en: 1'b1, acc: ACC_LOAD_P, w_load: 1'b1,
      sec_end: 1'b0, jmp: JMP_NEXT, finish: 1'b0},
    '{coef: CF_B0, src: SRC_W, mul_en: 1'b1, acc: ACC_ADD, w_load: 1'b0,
      sec_end: 1'b0, jmp: JMP_NEXT, finish: 1'b0},
    '{coef: CF_B0, src: SRC_W, mul_en: 1'b0, acc: ACC_ADD, w_load: 1'b0,
      sec_end: 1'b0, jmp: JMP_NEXT, finish: 1'b0},
    '{coef: CF_B0, src: SRC_W, mul_en: 1'b0, acc: ACC_HOLD, w_load: 1'b0,
      sec_end: 1'b1, jmp: JMP_LOOP, finish: 1'b0},
    '{coef: CF_B0, src: SRC_W, mul_en: 1'b0, acc: ACC_HOLD, w_load: 1'b0,
      sec_end: 1'b0, jmp: JMP_END, finish: 1'b1}
  };

  // coefficient lookup for one section and tap
  function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [SEC_W-1:0] sec,
                                                           input coef_sel_t sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      CF_B0: c = COEF_TAB[sec][0];
      CF_B1: c = COEF_TAB[sec][1];
      CF_B2: c = COEF_TAB[sec][2];
      CF_A1: c = COEF_TAB[sec][3];
      CF_A2: c = COEF_TAB[sec][4];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/ebc_useq.sv
// microcode sequencer: program counter, section counter and control rom
module ebc_useq #(
  parameter int SECTIONS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_blocked,
  output ebc_pkg::ebc_ctl_t ctl
);
  import ebc_pkg::*;

  localparam int NACT = (SECTIONS < COEF_SETS) ? SECTIONS : COEF_SETS;
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(NACT - 1);

  seq_state_t        state, state_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [SEC_W-1:0]  sec, sec_next;
  uword_t            uw;
  logic              accept;
  logic              fire;

  // control rom read
  assign uw     = UPROG[pc];
  assign accept = (state == SEQ_IDLE) && in_valid;
  assign fire   = (state == SEQ_RUN) && !(uw.finish && out_blocked);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (in_valid) state_next = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (fire && (uw.jmp == JMP_END)) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // step and section counters with conditional jump
  always_comb begin
    pc_next  = pc;
    sec_next = sec;
    if (accept) begin
      pc_next  = '0;
      sec_next = '0;
    end else if (fire) begin
      case (uw.jmp)
        JMP_NEXT: pc_next = pc + PC_W'(1);
        JMP_LOOP: begin
          if (sec == SEC_LAST) begin
            pc_next  = pc + PC_W'(1);
            sec_next = '0;
          end else begin
            pc_next  = '0;
            sec_next = sec + SEC_W'(1);
          end
        end
        JMP_END: pc_next = '0;
        default: pc_next = '0;
      endcase
    end
  end

  // outputs
  always_comb begin
    in_stall  = (state == SEQ_RUN);
    ctl.uw    = uw;
    ctl.fire  = fire;
    ctl.start = accept;
    ctl.sec   = sec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= '0;
      sec   <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      sec   <= sec_next;
    end
  end

endmodule

FILE: rtl/core/ebc_datapath.sv
// datapath: shared multiply-accumulate, delay store, clamps and output register
module ebc_datapath #(
  parameter int DELAY_WIDTH = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ebc_pkg::ebc_ctl_t                   ctl,
  input  logic                                cfg_write,
  input  logic [ebc_pkg::SAMPLE_W-1:0]        cfg_data,
  input  logic [ebc_pkg::SAMPLE_W-1:0]        raw_sample,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [ebc_pkg::OUT_W-1:0]    filtered_sample,
  output logic                                saturated,
  output logic                                out_blocked
);
  import ebc_pkg::*;

  localparam int DW     = DELAY_WIDTH;
  localparam int PROD_W = DW + COEF_W;
  // rounded product and accumulator share one width (three guard bits over DW)
  localparam int ACC_W  = PROD_W - PROD_SHIFT;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int Q_W    = ACC_W + 1 - OUT_SHIFT;
  localparam logic [SAMPLE_W-1:0] SMASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  logic [SAMPLE_W-1:0]       midpoint;
  logic [SAMPLE_W-1:0]       raw_m, mid_m;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   x_in;
  logic signed [ACC_W-1:0]   xreg;
  logic signed [ACC_W-1:0]   acc, acc_next;
  logic signed [DW-1:0]      z1_mem [COEF_SETS];
  logic signed [DW-1:0]      z2_mem [COEF_SETS];
  logic signed [DW-1:0]      z1, z2, w;
  logic signed [DW-1:0]      mul_op;
  logic signed [COEF_W-1:0]  coef_v;
  logic signed [PROD_W-1:0]  prod, prod_mul, prod_rnd_sum;
  logic signed [ACC_W-1:0]   rnd;
  logic                      acc_fits;
  logic signed [DW-1:0]      acc_clamp;
  logic                      sat_acc;
  logic signed [ACC_W:0]     out_sum;
  logic signed [Q_W-1:0]     out_q;
  logic                      out_fits;
  logic signed [OUT_W-1:0]   out_clamp;

  // centered input scaled to Q12
  always_comb begin
    raw_m = raw_sample & SMASK;
    mid_m = midpoint & SMASK;
    diff  = $signed({1'b0, raw_m}) - $signed({1'b0, mid_m});
    x_in  = {{(ACC_W - DIFF_W - X_FRAC){diff[DIFF_W-1]}}, diff, {X_FRAC{1'b0}}};
  end

  // operand select and multiplier
  always_comb begin
    z1     = z1_mem[ctl.sec];
    z2     = z2_mem[ctl.sec];
    coef_v = coef_lookup(ctl.sec, ctl.uw.coef);
    case (ctl.uw.src)
      SRC_Z1:  mul_op = z1;
      SRC_Z2:  mul_op = z2;
      SRC_W:   mul_op = w;
      default: mul_op = w;
    endcase
    prod_mul = PROD_W'(coef_v) * PROD_W'(mul_op);
  end

  // round registered product to Q12, nearest with ties upward
  always_comb begin
    prod_rnd_sum = prod + PROD_W'(ROUND_HALF);
    rnd          = prod_rnd_sum[PROD_W-1:PROD_SHIFT];
  end

  // accumulator update
  always_comb begin
    case (ctl.uw.acc)
      ACC_HOLD:   acc_next = acc;
      ACC_LOAD_X: acc_next = xreg;
      ACC_SUB:    acc_next = acc - rnd;
      ACC_ADD:    acc_next = acc + rnd;
      ACC_LOAD_P: acc_next = rnd;
      default:    acc_next = acc;
    endcase
  end

  // clamp accumulator to the delay word range
  always_comb begin
    acc_fits = (&acc[ACC_W-1:DW-1]) || !(|acc[ACC_W-1:DW-1]);
    if (acc_fits) begin
      acc_clamp = acc[DW-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_clamp = {1'b1, {(DW-1){1'b0}}};
    end else begin
      acc_clamp = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // final Q12 to Q4 rounding and 20-bit clamp
  always_comb begin
    out_sum  = (ACC_W+1)'(xreg) + (ACC_W+1)'(OUT_ROUND);
    out_q    = out_sum[ACC_W:OUT_SHIFT];
    out_fits = (&out_q[Q_W-1:OUT_W-1]) || !(|out_q[Q_W-1:OUT_W-1]);
    if (out_fits) begin
      out_clamp = out_q[OUT_W-1:0];
    end else if (out_q[Q_W-1]) begin
      out_clamp = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      out_clamp = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  assign out_blocked = out_valid && out_stall;

  // midpoint register
  always_ff @(posedge clk) begin
    if (rst) begin
      midpoint <= MIDPOINT_RESET;
    end else if (cfg_write) begin
      midpoint <= cfg_data;
    end
  end

  // delay store, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_SETS; i++) begin
        z1_mem[i] <= '0;
        z2_mem[i] <= '0;
      end
    end else if (ctl.fire && ctl.uw.sec_end) begin
      z1_mem[ctl.sec] <= w;
      z2_mem[ctl.sec] <= z1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      xreg <= x_in;
    end else if (ctl.fire && ctl.uw.sec_end) begin
      xreg <= ACC_W'(acc_clamp);
    end
    if (ctl.fire) begin
      acc <= acc_next;
      if (ctl.uw.mul_en) prod <= prod_mul;
      if (ctl.uw.w_load) w <= acc_clamp;
    end
  end

  // clip flag for the transaction in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_acc <= 1'b0;
    end else if (ctl.start) begin
      sat_acc <= 1'b0;
    end else if (ctl.fire && (ctl.uw.w_load || ctl.uw.sec_end) && !acc_fits) begin
      sat_acc <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire && ctl.uw.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.uw.finish) begin
      filtered_sample <= out_clamp;
      saturated       <= sat_acc || !out_fits;
    end
  end

endmodule

FILE: rtl/core/eeg_bandpass_biquad_cascade.sv
// top level of the eeg band-pass biquad cascade
//
// Input channel: raw_sample with in_valid/in_stall; a transaction completes
// on a rising edge with in_valid high and in_stall low. The midpoint set by
// cfg_write/cfg_data is subtracted, then the sample runs through the biquad
// sections on one shared multiplier driven by a small microprogram.
// Output channel: filtered_sample (Q4, saturated to 20 bits) and saturated,
// with out_valid/out_stall; one result per input transaction.
// Sequence: each of the min(SECTIONS,4) active sections forms five products
// through the one multiply-accumulate unit, then clamps and writes back its
// delays; a final step forms the output. A new sample is accepted only once
// the current one has finished, as in_stall stays high while it runs.
// Sections beyond the fourth pass their input through and cost nothing.
// A finished result sits in the output register while the receiver stalls;
// the next sample is still accepted and computed, and only its last step
// waits until the output register frees up.
// Reset (rst, synchronous) clears the delay store, sets the midpoint to 2048
// and drops out_valid and in_stall. Write the midpoint only while idle.
module eeg_bandpass_biquad_cascade #(
  parameter int SECTIONS    = 4,
  parameter int DELAY_WIDTH = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ebc_pkg::SAMPLE_W-1:0]     cfg_data,
  input  logic [ebc_pkg::SAMPLE_W-1:0]     raw_sample,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic signed [ebc_pkg::OUT_W-1:0] filtered_sample,
  output logic                             saturated,
  output logic                             out_valid,
  input  logic                             out_stall
);
  import ebc_pkg::*;

  ebc_ctl_t ctl;
  logic     out_blocked;

  // step sequencer
  ebc_useq #(
    .SECTIONS (SECTIONS)
  ) u_useq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_blocked (out_blocked),
    .ctl         (ctl)
  );

  // arithmetic and storage
  ebc_datapath #(
    .DELAY_WIDTH (DELAY_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .raw_sample      (raw_sample),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .filtered_sample (filtered_sample),
    .saturated       (saturated),
    .out_blocked     (out_blocked)
  );

endmodule
